@@ design/dpi_pkg.sv @@
// ----------------------------------------------------------------------------
// dpi_pkg: shared definitions for the damped particle integrator
// Widths, register indexes, control types and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
package dpi_pkg;

  localparam int TIME_BITS = 10;                 // tick bits used by the power
  localparam int TIME_W    = 10;                 // time_step field width
  localparam int Q_W       = 32;                 // Q16.16 word
  localparam int FRAC_W    = 16;
  localparam int DAMP_W    = 17;                 // unsigned Q0.16 incl. 1.0
  localparam int AXES      = 3;
  localparam int CFG_AW    = 2;
  localparam int CNT_W     = $clog2(TIME_BITS + 1);
  localparam int PT_W      = Q_W + TIME_BITS + 1;   // signed value times ticks
  localparam int VR_W      = Q_W + DAMP_W + 1;      // velocity times power
  localparam int SUM_W     = PT_W + 1;
  localparam int IN_TDATA_W  = ((TIME_W + 2 * AXES * Q_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * AXES * Q_W;

  localparam logic [DAMP_W-1:0] DAMP_ONE = DAMP_W'(1) << FRAC_W;

  typedef enum logic [CFG_AW-1:0] {
    REG_DAMPING = 2'd0,
    REG_ACCEL_X = 2'd1,
    REG_ACCEL_Y = 2'd2,
    REG_ACCEL_Z = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;     // overwrite position and velocity
    logic prep;     // capture velocity*t and accel*t
    logic mul;      // capture velocity*power
    logic commit;   // write back the saturated sums
  } lane_ctrl_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-Q_W:0] top;
    top = v[SUM_W-1:Q_W-1];
    if ((&top) || !(|top)) begin
      return v[Q_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ design/dpi_power.sv @@
// ----------------------------------------------------------------------------
// dpi_power: damping power unit
// Square-and-multiply over the tick bits, one bit per cycle, unsigned Q0.16.
// ----------------------------------------------------------------------------
module dpi_power
  import dpi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DAMP_W-1:0]    damping,
  input  logic [TIME_BITS-1:0] ticks,
  output logic                 busy,
  output logic [DAMP_W-1:0]    power
);

  logic [DAMP_W-1:0]    base;
  logic [TIME_BITS-1:0] tsh;
  logic [CNT_W-1:0]     cnt;
  logic [2*DAMP_W-1:0]  rb_prod;
  logic [2*DAMP_W-1:0]  bb_prod;

  assign rb_prod = (2*DAMP_W)'(power) * (2*DAMP_W)'(base);
  assign bb_prod = (2*DAMP_W)'(base) * (2*DAMP_W)'(base);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(TIME_BITS);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      power <= DAMP_ONE;
      base  <= damping;
      tsh   <= ticks;
    end else if (busy) begin
      // truncate both products back to Q0.16
      if (tsh[0]) begin
        power <= rb_prod[FRAC_W +: DAMP_W];
      end
      base <= bb_prod[FRAC_W +: DAMP_W];
      tsh  <= tsh >> 1;
    end
  end

endmodule

@@ design/dpi_lane.sv @@
// ----------------------------------------------------------------------------
// dpi_lane: one axis of the integrator
// Holds position and velocity of one axis and forms the Euler update.
// ----------------------------------------------------------------------------
module dpi_lane
  import dpi_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  lane_ctrl_t                  ctrl,
  input  logic [TIME_BITS-1:0]        ticks,
  input  logic [DAMP_W-1:0]           power,
  input  logic signed [Q_W-1:0]       accel,
  input  logic signed [Q_W-1:0]       load_pos,
  input  logic signed [Q_W-1:0]       load_vel,
  output logic signed [Q_W-1:0]       pos,
  output logic signed [Q_W-1:0]       vel
);

  logic signed [PT_W-1:0]  vt;
  logic signed [PT_W-1:0]  at;
  logic signed [VR_W-1:0]  vr;
  logic signed [VR_W-1:0]  vr_sh;
  logic signed [SUM_W-1:0] pos_sum;
  logic signed [SUM_W-1:0] vel_sum;
  logic signed [TIME_BITS:0] ticks_s;
  logic signed [DAMP_W:0]    power_s;

  assign ticks_s = $signed({1'b0, ticks});
  assign power_s = $signed({1'b0, power});

  // arithmetic shift gives floor of the Q16 product
  assign vr_sh   = vr >>> FRAC_W;
  assign pos_sum = SUM_W'(pos) + SUM_W'(vt);
  assign vel_sum = SUM_W'(vr_sh) + SUM_W'(at);

  always_ff @(posedge clk) begin
    if (ctrl.prep) begin
      vt <= PT_W'(vel) * PT_W'(ticks_s);
      at <= PT_W'(accel) * PT_W'(ticks_s);
    end
    if (ctrl.mul) begin
      vr <= VR_W'(vel) * VR_W'(power_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
    end else if (ctrl.load) begin
      pos <= load_pos;
      vel <= load_vel;
    end else if (ctrl.commit) begin
      pos <= sat32(pos_sum);
      vel <= sat32(vel_sum);
    end
  end

endmodule

@@ design/damped_particle_integrator.sv @@
// ----------------------------------------------------------------------------
// damped_particle_integrator: Euler integrator with damping, three axes
// Integrate items step through the power, multiply, add and output states; the damping
// power unit, one tick bit per cycle, sets how long the power state lasts.
// Load items go straight to output; a new item waits until the last result is registered.
// Reset clears position, velocity, acceleration and sets damping to 1.0.
// ----------------------------------------------------------------------------
module damped_particle_integrator
  import dpi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // time_step[9:0], load_pos_x, load_pos_y, load_pos_z,
  // load_vel_x, load_vel_y, load_vel_z, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,    // req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [Q_W-1:0]         cfg_data
);

  state_t state, state_next;
  lane_ctrl_t ctrl;

  logic [DAMP_W-1:0]     damping;
  logic signed [Q_W-1:0] accel [AXES];
  logic signed [Q_W-1:0] pos   [AXES];
  logic signed [Q_W-1:0] vel   [AXES];

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic                 pow_busy;
  logic [DAMP_W-1:0]    power;
  logic [TIME_BITS-1:0] ticks;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ticks    = TIME_BITS'(s_tdata[TIME_W-1:0]);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      damping <= DAMP_ONE;
      for (int i = 0; i < AXES; i++) begin
        accel[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DAMPING: begin
          // drop a damping above one
          if (cfg_data[DAMP_W-1:0] <= DAMP_ONE) begin
            damping <= cfg_data[DAMP_W-1:0];
          end
        end
        REG_ACCEL_X: accel[0] <= cfg_data;
        REG_ACCEL_Y: accel[1] <= cfg_data;
        REG_ACCEL_Z: accel[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = s_tuser ? ST_OUT : ST_POW;
        end
      end
      ST_POW: begin
        if (!pow_busy) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = (state == ST_IDLE);
    ctrl.load   = accept && s_tuser;
    ctrl.prep   = accept && !s_tuser;
    ctrl.mul    = (state == ST_MUL);
    ctrl.commit = (state == ST_ADD);
    out_load    = (state == ST_OUT) && out_free;
  end

  dpi_power u_power (
    .clk     (clk),
    .rst     (rst),
    .start   (ctrl.prep),
    .damping (damping),
    .ticks   (ticks),
    .busy    (pow_busy),
    .power   (power)
  );

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    dpi_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .ticks    (ticks),
      .power    (power),
      .accel    (accel[g]),
      .load_pos (s_tdata[TIME_W + g * Q_W +: Q_W]),
      .load_vel (s_tdata[TIME_W + (AXES + g) * Q_W +: Q_W]),
      .pos      (pos[g]),
      .vel      (vel[g])
    );
  end

  // merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < AXES; i++) begin
        m_tdata[i * Q_W +: Q_W]          <= pos[i];
        m_tdata[(AXES + i) * Q_W +: Q_W] <= vel[i];
      end
    end
  end

  a_idle_power_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pow_busy)
    else $error("power unit busy while sequencer idle");

  a_load_to_out: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |=> (state == ST_OUT))
    else $error("load transfer did not go straight to output");

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("result raised outside the output step");

  a_commit_after_mul: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |-> $past(ctrl.mul))
    else $error("commit without a preceding power multiply");

endmodule

@@ tb/tb_damped_particle_integrator.sv @@
// ----------------------------------------------------------------------------
// tb_damped_particle_integrator: self-checking bench for the particle integrator
// Drives a short table of directed load and integrate transfers, then phases of
// random traffic under changing damping and acceleration settings. Every result
// is compared per field with its row's typed expectation or an in-bench Q16.16
// integrator, under random stalls on both stream sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_damped_particle_integrator;
  import dpi_pkg::*;

  typedef logic [OUT_TDATA_W-1:0] kin_t;   // pos_x lowest, vel_z highest

  typedef struct packed {
    logic              req;
    logic [TIME_W-1:0] ticks;
    kin_t              load;
    logic              has_exp;
    kin_t              exp;
  } row_t;

  localparam logic [Q_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int SETTLE      = 24;   // integrate latency plus margin
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 3000;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [Q_W-1:0]         cfg_data = '0;

  // expectation typed into a directed row, carried along with its transfer
  logic row_has_exp = 1'b0;
  kin_t row_exp = '0;

  kin_t  expected_kin [$];
  int    fail_count = 0;
  int    idle_cycles = 0;
  bit    calm = 1'b0;
  int    hold_asked = 0;
  string kin_name [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

  // in-bench copy of the particle and its settings
  longint      trk_pos [AXES];
  longint      trk_vel [AXES];
  longint      trk_accel [AXES];
  int unsigned trk_damping;

  damped_particle_integrator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic kin_t kin(input logic [Q_W-1:0] px, py, pz, vx, vy, vz);
    return {vz, vy, vx, pz, py, px};
  endfunction

  function automatic longint clamp_q16(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // one Euler step (or a load) on the tracked particle; returns the new state
  function automatic kin_t advance_particle(input logic req, input logic [TIME_W-1:0] ticks,
                                            input kin_t load);
    longint unsigned r;
    longint unsigned b;
    longint          rs;
    longint          t;
    longint          v;
    logic signed [Q_W-1:0] w;
    kin_t            res;
    if (req) begin
      for (int i = 0; i < AXES; i++) begin
        w = load[Q_W*i +: Q_W];
        trk_pos[i] = w;
        w = load[Q_W*(AXES+i) +: Q_W];
        trk_vel[i] = w;
      end
    end else begin
      r = 65536;
      b = trk_damping;
      for (int i = 0; i < TIME_BITS; i++) begin
        if (ticks[i]) r = (r * b) >> 16;
        b = (b * b) >> 16;
      end
      rs = r;
      t = ticks;
      for (int i = 0; i < AXES; i++) begin
        v = trk_vel[i];
        trk_pos[i] = clamp_q16(trk_pos[i] + v * t);
        trk_vel[i] = clamp_q16(((v * rs) >>> 16) + trk_accel[i] * t);
      end
    end
    for (int i = 0; i < AXES; i++) begin
      res[Q_W*i +: Q_W] = trk_pos[i][Q_W-1:0];
      res[Q_W*(AXES+i) +: Q_W] = trk_vel[i][Q_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [Q_W-1:0] rand_q16();
    logic [Q_W-1:0] v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      3: v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      default: begin
        case ($urandom_range(0, 3))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  // mirror register writes, predict and compare results
  always @(posedge clk) begin : check_results
    kin_t want;
    kin_t pred;
    if (rst) begin
      trk_damping = 32'(DAMP_ONE);
      for (int i = 0; i < AXES; i++) begin
        trk_pos[i] = 0;
        trk_vel[i] = 0;
        trk_accel[i] = 0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_addr) == REG_DAMPING) begin
          if (cfg_data[DAMP_W-1:0] <= DAMP_ONE) trk_damping = 32'(cfg_data[DAMP_W-1:0]);
        end else begin
          trk_accel[cfg_addr - 2'd1] = longint'($signed(cfg_data));
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_kin.size() == 0) begin
          $error("result transfer with nothing pending: %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_kin.pop_front();
          for (int i = 0; i < 2 * AXES; i++) begin
            if (m_tdata[Q_W*i +: Q_W] !== want[Q_W*i +: Q_W]) begin
              $error("%s: expected %0d, actual %0d", kin_name[i],
                     $signed(want[Q_W*i +: Q_W]), $signed(m_tdata[Q_W*i +: Q_W]));
              fail_count++;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pred = advance_particle(s_tuser, s_tdata[TIME_W-1:0], s_tdata[TIME_W +: OUT_TDATA_W]);
        expected_kin.push_back(row_has_exp ? row_exp : pred);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // output side: random stall bursts, one long hold on request
  initial begin : sink
    int span;
    int hold_seen;
    hold_seen = 0;
    forever begin
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        m_tready <= 1'b0;
        span = LONG_HOLD;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        span = $urandom_range(1, 17);
      end else begin
        m_tready <= 1'b1;
        span = $urandom_range(1, 40);
      end
      repeat (span) @(posedge clk);
    end
  end

  task automatic offer(input logic req, input logic [TIME_W-1:0] ticks, input kin_t load,
                       input logic has_exp, input kin_t exp);
    s_tvalid    <= 1'b1;
    s_tuser     <= req;
    s_tdata     <= IN_TDATA_W'({load, ticks});
    row_has_exp <= has_exp;
    row_exp     <= exp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // one extra edge so the transfer just made is already queued
  task automatic wait_drain();
    @(posedge clk);
    while (expected_kin.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [Q_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic add_row(input logic req, input logic [TIME_W-1:0] ticks, input kin_t load,
                         input logic has_exp, input kin_t exp, inout row_t rows [$]);
    row_t r;
    r.req = req;
    r.ticks = ticks;
    r.load = load;
    r.has_exp = has_exp;
    r.exp = exp;
    rows.push_back(r);
  endtask

  initial begin : stimulus
    row_t                rows [$];
    kin_t                loaded;
    kin_t                ones;
    logic [TIME_W-1:0]   t;
    logic [DAMP_W-1:0]   d;
    logic [Q_W-1:0]      word;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset state, extremes, saturation, zero ticks, ignored fields
    ones = '1;
    loaded = kin(Q_MAX, Q_MIN, '0, Q_MAX, Q_MIN, Q_ONE);
    add_row(1'b0, 10'd5, ones, 1'b1, '0, rows);
    add_row(1'b0, 10'd0, '0, 1'b1, '0, rows);
    add_row(1'b1, 10'h3FF, loaded, 1'b1, loaded, rows);
    add_row(1'b0, 10'd0, {6{32'hAAAA_AAAA}}, 1'b1, loaded, rows);
    add_row(1'b0, 10'h3FF, ones, 1'b1,
            kin(Q_MAX, Q_MIN, 32'h03FF_0000, Q_MAX, Q_MIN, Q_ONE), rows);
    add_row(1'b1, 10'h155, '0, 1'b1, '0, rows);
    loaded = kin('1, 32'h0000_0001, Q_MIN, '1, 32'h0000_8000, Q_MAX);
    add_row(1'b1, 10'h3FF, loaded, 1'b1, loaded, rows);
    add_row(1'b0, 10'd1, ones, 1'b0, '0, rows);
    add_row(1'b0, 10'd2, '0, 1'b0, '0, rows);
    add_row(1'b0, 10'd512, ones, 1'b0, '0, rows);
    add_row(1'b0, 10'h3FF, '0, 1'b0, '0, rows);
    loaded = kin(32'h5555_5555, 32'hAAAA_AAAA, 32'h0012_3400,
                 32'hFFFE_8000, 32'h0000_4000, 32'hAAAA_5555);
    add_row(1'b1, 10'd0, loaded, 1'b1, loaded, rows);
    add_row(1'b0, 10'h2AA, '0, 1'b0, '0, rows);
    add_row(1'b0, 10'h155, ones, 1'b0, '0, rows);
    add_row(1'b1, 10'h2AA, '0, 1'b1, '0, rows);
    add_row(1'b0, 10'd0, ones, 1'b1, '0, rows);

    foreach (rows[i]) begin
      offer(rows[i].req, rows[i].ticks, rows[i].load, rows[i].has_exp, rows[i].exp);
      sender_gap();
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      s_tvalid <= 1'b0;
      wait_drain();
      repeat (SETTLE) @(posedge clk);
      case (ph)
        0: begin
          write_reg(REG_DAMPING, '0);
          write_reg(REG_ACCEL_X, Q_MAX);
          write_reg(REG_ACCEL_Y, Q_MIN);
          write_reg(REG_ACCEL_Z, '0);
        end
        1: begin
          write_reg(REG_DAMPING, Q_W'(DAMP_ONE));
          write_reg(REG_ACCEL_X, $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
          write_reg(REG_ACCEL_Y, $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
          write_reg(REG_ACCEL_Z, $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
        end
        2: begin
          // the two values above one must leave 0.75 in place
          write_reg(REG_DAMPING, 32'h0000_C000);
          write_reg(REG_DAMPING, 32'h0001_FFFF);
          write_reg(REG_DAMPING, 32'h0001_0001);
          write_reg(REG_ACCEL_X, rand_q16());
          write_reg(REG_ACCEL_Y, rand_q16());
          write_reg(REG_ACCEL_Z, rand_q16());
        end
        default: begin
          case ($urandom_range(0, 4))
            0: d = DAMP_ONE - DAMP_W'($urandom_range(0, 64));
            1: d = DAMP_W'($urandom_range(0, 65536));
            2: d = DAMP_W'($urandom_range(0, 17'h1FFFF));
            3: d = $urandom_range(0, 1) ? '0 : DAMP_ONE;
            default: d = DAMP_ONE - DAMP_W'($urandom_range(0, 4096));
          endcase
          word = $urandom_range(0, 1) ? $urandom : '0;
          word[DAMP_W-1:0] = d;
          write_reg(REG_DAMPING, word);
          write_reg(REG_ACCEL_X, rand_q16());
          write_reg(REG_ACCEL_Y, rand_q16());
          write_reg(REG_ACCEL_Z, rand_q16());
        end
      endcase
      cfg_we <= 1'b0;
      if (ph == N_PHASES - 1) calm = 1'b1;
      if (ph == 2) hold_asked++;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          offer(1'b1, TIME_W'($urandom),
                kin(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16()),
                1'b0, '0);
        end else begin
          case ($urandom_range(0, 5))
            0, 1, 2: t = TIME_W'($urandom_range(0, 15));
            3: t = TIME_W'(1) << $urandom_range(0, TIME_W - 1);
            default: t = TIME_W'($urandom);
          endcase
          offer(1'b0, t, kin($urandom, $urandom, $urandom, $urandom, $urandom, $urandom),
                1'b0, '0);
        end
        if (ph == 4 && k == PHASE_ITEMS / 2) begin
          // hold the input until the pipeline is empty
          s_tvalid <= 1'b0;
          wait_drain();
        end else begin
          sender_gap();
        end
      end
    end

    s_tvalid <= 1'b0;
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && expected_kin.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/dpi_pkg.sv
design/dpi_power.sv
design/dpi_lane.sv
design/damped_particle_integrator.sv
tb/tb_damped_particle_integrator.sv
